### hdl/bn_inf_pkg.sv
package bn_inf_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] REG_UNIT_COUNT    = 2'd1;
   localparam logic [1:0] REG_EPSILON       = 2'd2;

   // item kinds carried in req_tuser
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // iteration counts of the factor units
   localparam int DIV_STEPS  = 49;
   localparam int ROOT_STEPS = 16;

   // request payload width: channel_index, scale, bias, mean, variance, sample
   localparam int REQ_BITS = 96;

   typedef struct packed {
      logic load_start;
      logic square;
      logic div_step;
      logic root_start;
      logic root_step;
      logic store;
      logic sample_start;
      logic mult;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_blocked;
   } status_type;

endpackage

### hdl/bn_inf_ctrl.sv
module bn_inf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_op,
   output logic                   req_tready,
   input  bn_inf_pkg::status_type status,
   output bn_inf_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQUARE, ST_DIVIDE, ST_ROOT_INIT, ST_ROOT, ST_STORE, ST_MULT, ST_FINISH
   } state_type;

   state_type  state_ff;
   logic [5:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= (req_op == bn_inf_pkg::OP_LOAD) ? ST_SQUARE : ST_MULT;
               end
            end
            ST_SQUARE: begin
               state_ff <= ST_DIVIDE;
               cnt_ff   <= '0;
            end
            ST_DIVIDE: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(bn_inf_pkg::DIV_STEPS - 1)) begin
                  state_ff <= ST_ROOT_INIT;
               end
            end
            ST_ROOT_INIT: begin
               state_ff <= ST_ROOT;
               cnt_ff   <= '0;
            end
            ST_ROOT: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(bn_inf_pkg::ROOT_STEPS - 1)) begin
                  state_ff <= ST_STORE;
               end
            end
            ST_STORE: state_ff <= ST_IDLE;
            ST_MULT:  state_ff <= ST_FINISH;
            ST_FINISH: begin
               if (!status.out_blocked) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd              = '0;
      cmd.load_start   = (state_ff == ST_IDLE) && req_tvalid && (req_op == bn_inf_pkg::OP_LOAD);
      cmd.sample_start = (state_ff == ST_IDLE) && req_tvalid && (req_op == bn_inf_pkg::OP_SAMPLE);
      cmd.square       = (state_ff == ST_SQUARE);
      cmd.div_step     = (state_ff == ST_DIVIDE);
      cmd.root_start   = (state_ff == ST_ROOT_INIT);
      cmd.root_step    = (state_ff == ST_ROOT);
      cmd.store        = (state_ff == ST_STORE);
      cmd.mult         = (state_ff == ST_MULT);
      cmd.out_load     = (state_ff == ST_FINISH) && !status.out_blocked;
   end

endmodule

### hdl/bn_inf_datapath.sv
module bn_inf_datapath #(
   parameter int MAX_CHANNELS = 256,
   parameter int DATA_WIDTH   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bn_inf_pkg::cmd_type             cmd,
   output bn_inf_pkg::status_type          status,
   input  logic [bn_inf_pkg::REQ_BITS-1:0] req_data,
   input  logic                            csr_valid,
   input  logic [1:0]                      csr_index,
   input  logic [23:0]                     csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [DATA_WIDTH-1:0]    rsp_y,
   output logic [7:0]                      rsp_channel,
   output logic                            rsp_last,
   output logic                            rsp_sat
);

   localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic signed [35:0] YMAX = (36'sd1 <<< (DATA_WIDTH - 1)) - 36'sd1;
   localparam logic signed [35:0] YMIN = -YMAX - 36'sd1;

   // request fields
   logic [7:0]         f_ch;
   logic signed [15:0] f_scale, f_bias, f_mean, f_sample;
   logic [23:0]        f_var;
   assign f_ch     = req_data[7:0];
   assign f_scale  = req_data[23:8];
   assign f_bias   = req_data[39:24];
   assign f_mean   = req_data[55:40];
   assign f_var    = req_data[79:56];
   assign f_sample = req_data[95:80];

   // configuration
   logic [8:0]  chan_count_ff;
   logic [16:0] units_cfg_ff;
   logic [23:0] epsilon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= 9'd1;
         units_cfg_ff  <= 17'd1;
         epsilon_ff    <= 24'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            bn_inf_pkg::REG_CHANNEL_COUNT: chan_count_ff <= csr_wdata[8:0];
            bn_inf_pkg::REG_UNIT_COUNT:    units_cfg_ff  <= csr_wdata[16:0];
            bn_inf_pkg::REG_EPSILON:       epsilon_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // load path: operands, divider, square root
   logic [7:0]  ld_ch_ff;
   logic        ld_neg_ff, ld_zero_ff;
   logic [15:0] ld_bias_ff, ld_mean_ff;
   logic [15:0] s_abs_ff;
   logic [24:0] v_ff;
   logic [48:0] num_ff;
   logic [24:0] rem_ff;
   logic [25:0] div_trial;
   logic        div_ge;
   logic [31:0] rad_ff;
   logic [15:0] root_ff;
   logic [18:0] srem_ff;
   logic [18:0] sq_shift, sq_trial;
   logic        sq_ge;
   logic [16:0] k_inc;
   logic [15:0] mag;
   logic [15:0] factor;
   logic        fclamp;
   logic [31:0] sq;

   assign sq        = s_abs_ff * s_abs_ff;
   assign div_trial = {rem_ff, num_ff[48]};
   assign div_ge    = div_trial >= {1'b0, v_ff};
   assign sq_shift  = {srem_ff[16:0], rad_ff[31:30]};
   assign sq_trial  = {1'b0, root_ff, 2'b01};
   assign sq_ge     = sq_shift >= sq_trial;

   // rounded magnitude from floor of the root
   assign k_inc = {1'b0, root_ff} + 17'd1;
   assign mag   = k_inc[16:1];

   always_comb begin
      if (ld_zero_ff) begin
         factor = '0;
         fclamp = 1'b0;
      end else if (ld_neg_ff) begin
         factor = 16'(-mag);
         fclamp = mag[15];
      end else begin
         factor = mag[15] ? 16'h7FFF : mag;
         fclamp = mag[15];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         ld_ch_ff   <= f_ch;
         ld_neg_ff  <= f_scale[15];
         ld_zero_ff <= (f_scale == '0);
         ld_bias_ff <= f_bias;
         ld_mean_ff <= f_mean;
         s_abs_ff   <= f_scale[15] ? 16'(-f_scale) : f_scale;
         v_ff       <= {1'b0, f_var} + {1'b0, epsilon_ff};
      end
      if (cmd.square) begin
         num_ff <= {1'b0, sq, 16'd0} << 2;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? 25'(div_trial - {1'b0, v_ff}) : div_trial[24:0];
         num_ff <= {num_ff[47:0], div_ge};
      end
      if (cmd.root_start) begin
         rad_ff  <= (num_ff[48:32] != '0) ? 32'hFFFF_FFFF : num_ff[31:0];
         root_ff <= '0;
         srem_ff <= '0;
      end
      if (cmd.root_step) begin
         srem_ff <= sq_ge ? (sq_shift - sq_trial) : sq_shift;
         root_ff <= {root_ff[14:0], sq_ge};
         rad_ff  <= {rad_ff[29:0], 2'b00};
      end
   end

   // position counters
   logic [7:0]  chan_pos_ff;
   logic [15:0] unit_pos_ff;
   logic [8:0]  cc_eff;
   logic [16:0] uc_eff;
   logic        last_chan, last_unit;

   always_comb begin
      if (chan_count_ff == '0) cc_eff = 9'd1;
      else if (int'(chan_count_ff) > MAX_CHANNELS) cc_eff = 9'(MAX_CHANNELS);
      else cc_eff = chan_count_ff;
      if (units_cfg_ff == '0) uc_eff = 17'd1;
      else if (units_cfg_ff > 17'd65536) uc_eff = 17'd65536;
      else uc_eff = units_cfg_ff;
   end

   assign last_chan = ({1'b0, chan_pos_ff} + 9'd1) >= cc_eff;
   assign last_unit = ({1'b0, unit_pos_ff} + 17'd1) >= uc_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff <= '0;
         unit_pos_ff <= '0;
      end else if (cmd.sample_start) begin
         if (last_unit) begin
            unit_pos_ff <= '0;
            chan_pos_ff <= last_chan ? 8'd0 : chan_pos_ff + 8'd1;
         end else begin
            unit_pos_ff <= unit_pos_ff + 16'd1;
         end
      end
   end

   // per-channel table: clamp, factor, mean, bias
   logic [48:0]   tbl_mem [MAX_CHANNELS];
   logic [48:0]   rd_ff;
   logic [AW-1:0] wr_addr, rd_addr;

   assign wr_addr = AW'(ld_ch_ff);
   assign rd_addr = (int'(chan_pos_ff) >= MAX_CHANNELS) ? '0 : AW'(chan_pos_ff);

   always_ff @(posedge clock) begin
      if (cmd.store && (int'(ld_ch_ff) < MAX_CHANNELS)) begin
         tbl_mem[wr_addr] <= {fclamp, factor, ld_mean_ff, ld_bias_ff};
      end
      if (cmd.sample_start) begin
         rd_ff <= tbl_mem[rd_addr];
      end
   end

   // sample path
   logic signed [15:0] x_ff;
   logic [7:0]         smp_ch_ff;
   logic               smp_end_ff;
   logic signed [32:0] prod_ff;
   logic signed [15:0] bias_ff;
   logic               fclamp_ff;
   logic signed [16:0] diff;
   logic signed [34:0] acc;
   logic signed [35:0] y_wide;
   logic signed [DATA_WIDTH-1:0] y_val;
   logic               y_sat;

   assign diff = 17'(x_ff) - 17'($signed(rd_ff[31:16]));

   always_ff @(posedge clock) begin
      if (cmd.sample_start) begin
         x_ff       <= f_sample;
         smp_ch_ff  <= chan_pos_ff;
         smp_end_ff <= last_unit && last_chan;
      end
      if (cmd.mult) begin
         prod_ff   <= diff * $signed(rd_ff[47:32]);
         bias_ff   <= rd_ff[15:0];
         fclamp_ff <= rd_ff[48];
      end
   end

   assign acc    = 35'(prod_ff) + 35'($signed({bias_ff, 8'd0})) + 35'sd128;
   assign y_wide = 36'($signed(acc[34:8]));

   always_comb begin
      if (y_wide > YMAX) begin
         y_val = DATA_WIDTH'(YMAX);
         y_sat = 1'b1;
      end else if (y_wide < YMIN) begin
         y_val = DATA_WIDTH'(YMIN);
         y_sat = 1'b1;
      end else begin
         y_val = DATA_WIDTH'(y_wide);
         y_sat = 1'b0;
      end
   end

   // output register
   logic                         rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_y_ff;
   logic [7:0]                   rsp_ch_ff;
   logic                         rsp_last_ff, rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_y_ff    <= y_val;
         rsp_ch_ff   <= smp_ch_ff;
         rsp_last_ff <= smp_end_ff;
         rsp_sat_ff  <= y_sat || fclamp_ff;
      end
   end

   assign status.out_blocked = rsp_valid_ff && !rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_y       = rsp_y_ff;
   assign rsp_channel = rsp_ch_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_sat     = rsp_sat_ff;

endmodule

### hdl/batch_norm_inference.sv
// channel  direction  signals                          content
// req      in         req_tvalid/tready/tdata/tuser    load or sample item, tuser = op
// rsp      out        rsp_tvalid/tready/tdata/tlast/tuser  normalized sample
// csr      in         csr_valid/ready/index/wdata      channels, units per channel, epsilon
//
// a sample passes the multiply and finish states into the result register, which it enters once
// that register is free; only then is the next item taken, while the result may still wait
// a load runs squaring, a 49-step bit-serial divider, a root setup and a 16-step
// bit-serial square root, then writes the table entry
// reset is synchronous; positions clear, registers return to 1, 1, 1; tables keep contents
// a stalled rsp side holds the sample path in its last stage until the register frees
module batch_norm_inference #(
   parameter int MAX_CHANNELS = 256,
   parameter int DATA_WIDTH   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // channel_index[7:0], scale[23:8], bias[39:24], mean[55:40],
   // variance[79:56], sample[95:80]
   input  logic [bn_inf_pkg::REQ_BITS-1:0] req_tdata,
   // op
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // y[DATA_WIDTH-1:0], channel above it, zero padded to bytes
   output logic [((DATA_WIDTH+15)/8)*8-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // saturated
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [23:0]                     csr_wdata
);

   localparam int RSP_BITS = ((DATA_WIDTH + 15) / 8) * 8;

   bn_inf_pkg::cmd_type    cmd;
   bn_inf_pkg::status_type status;
   logic signed [DATA_WIDTH-1:0] y;
   logic [7:0] channel;

   // config writes are always accepted
   assign csr_ready = 1'b1;

   bn_inf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bn_inf_datapath #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_tdata),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_y       (y),
      .rsp_channel (channel),
      .rsp_last    (rsp_tlast),
      .rsp_sat     (rsp_tuser)
   );

   // pack y low, channel above, pad with zeros
   assign rsp_tdata = RSP_BITS'({channel, y});

   // one item in flight: a transfer closes the request side next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an item is in flight");

   // never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten");

   // the controller issues at most one command per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("overlapping datapath commands");

   // a load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> !cmd.out_load)
      else $error("result after a load");

endmodule

### dv/bn_inf_checker.sv
`timescale 1ns / 100ps

module bn_inf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output int          error_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct {
      logic signed [15:0] y;
      logic [7:0]         channel;
      logic               image_end;
      logic               saturated;
   } norm_result_type;

   norm_result_type    norm_queue[$];
   logic signed [15:0] factor_mem[256];
   logic signed [15:0] mean_mem[256];
   logic signed [15:0] bias_mem[256];
   logic               clamp_mem[256];
   logic [8:0]         chan_total;
   logic [16:0]        unit_total;
   logic [23:0]        epsilon;
   int unsigned        chan_pos, unit_pos;

   assign pending_count = norm_queue.size();

   // rounded 256*|s|/sqrt(v), binary search on squared comparison
   function automatic int unsigned factor_mag(longint unsigned s_abs, longint unsigned v);
      longint unsigned t, k;
      int unsigned lo, hi, mid;
      t = (s_abs * s_abs) << 18;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         k = 2 * longint'(mid) - 1;
         if (k * k * v <= t) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   task automatic report(string what, int got, int want);
      $display("%0t error: %s got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic load_channel(logic [95:0] d);
      logic [7:0]         ch;
      logic signed [15:0] s;
      longint unsigned    v;
      int unsigned        m;
      longint             f;
      logic               cl;
      ch = d[7:0];
      s  = d[23:8];
      v  = longint'(d[79:56]) + longint'(epsilon);
      f  = 0;
      cl = 0;
      if (s != 0) begin
         m = factor_mag(s < 0 ? -longint'(s) : longint'(s), v);
         if (s > 0) begin
            if (m > 32767) begin m = 32767; cl = 1; end
            f = m;
         end else begin
            if (m >= 32768) begin m = 32768; cl = 1; end
            f = -longint'(m);
         end
      end
      factor_mem[ch] = f[15:0];
      bias_mem[ch]   = d[39:24];
      mean_mem[ch]   = d[55:40];
      clamp_mem[ch]  = cl;
   endtask

   task automatic predict_sample(logic signed [15:0] x);
      int unsigned     cc, uc, c;
      longint          acc, y;
      logic            last_u, last_c;
      norm_result_type r;
      cc = chan_total == 0 ? 1 : chan_total;
      uc = unit_total == 0 ? 1 : unit_total;
      if (cc > 256) cc = 256;
      if (uc > 65536) uc = 65536;
      c = chan_pos;
      acc = (longint'(x) - longint'(mean_mem[c])) * longint'(factor_mem[c])
            + longint'(bias_mem[c]) * 256 + 128;
      y = acc >>> 8;
      r.saturated = clamp_mem[c];
      if (y > 32767) begin y = 32767; r.saturated = 1; end
      if (y < -32768) begin y = -32768; r.saturated = 1; end
      last_u = unit_pos + 1 >= uc;
      last_c = chan_pos + 1 >= cc;
      r.y = y[15:0];
      r.channel = chan_pos[7:0];
      r.image_end = last_u && last_c;
      norm_queue.push_back(r);
      if (last_u) begin
         unit_pos = 0;
         chan_pos = last_c ? 0 : ((chan_pos + 1) & 8'hff);
      end else begin
         unit_pos = (unit_pos + 1) & 16'hffff;
      end
   endtask

   always @(posedge clock) begin
      norm_result_type e;
      if (reset) begin
         chan_pos     = 0;
         unit_pos     = 0;
         chan_total   = 1;
         unit_total   = 1;
         epsilon      = 1;
         error_count  = 0;
         result_count = 0;
         norm_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bn_inf_pkg::REG_CHANNEL_COUNT: chan_total = csr_wdata[8:0];
               bn_inf_pkg::REG_UNIT_COUNT:    unit_total = csr_wdata[16:0];
               bn_inf_pkg::REG_EPSILON:       epsilon = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == bn_inf_pkg::OP_LOAD) load_channel(req_tdata);
            else predict_sample(req_tdata[95:80]);
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (norm_queue.size() == 0) begin
               report("unexpected result", rsp_tdata[15:0], 0);
            end else begin
               e = norm_queue.pop_front();
               if (rsp_tdata[15:0] !== e.y) report("y", $signed(rsp_tdata[15:0]), e.y);
               if (rsp_tdata[23:16] !== e.channel) report("channel", rsp_tdata[23:16], e.channel);
               if (rsp_tlast !== e.image_end) report("image_end", rsp_tlast, e.image_end);
               if (rsp_tuser !== e.saturated) report("saturated", rsp_tuser, e.saturated);
            end
         end
      end
   end
endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = bn_inf_pkg::OP_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = bn_inf_pkg::REG_CHANNEL_COUNT;
   logic [23:0] csr_wdata = '0;
   int          error_count, pending_count, result_count;
   int          cycle_count = 0;
   int          loads_sent = 0, samples_sent = 0;

   // the tail wait covers a load still running its divider and square root
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 900000;
   // an index past the three registers
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic [8:0] active_channels;

   always #5 clock = ~clock;

   batch_norm_inference dut (.*);

   bn_inf_checker checker_i (.*);

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("batch_norm_inference: mismatch");
         $finish;
      end
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver stall pattern, independent of the sender
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) rsp_tready <= 0;
      else rsp_tready <= (cycle_count % 2000 < 300) ? 1'b1 : (r < 70);
   end

   task automatic idle(int n);
      repeat (n) @(posedge clock);
   endtask

   // valid stays up between back-to-back items; drain drops it
   task automatic send(logic op, logic [95:0] d);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_tvalid <= 0;
         idle(n);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == bn_inf_pkg::OP_LOAD) loads_sent++;
      else samples_sent++;
   endtask

   task automatic load_param(logic [7:0] ch, logic [15:0] s, logic [15:0] b,
                             logic [15:0] m, logic [23:0] v);
      send(bn_inf_pkg::OP_LOAD, {16'($urandom), v, m, b, s, ch});
   endtask

   task automatic sample(logic [15:0] x);
      // variance/scale lanes carry junk on samples
      send(bn_inf_pkg::OP_SAMPLE, {x, 80'({$urandom, $urandom, $urandom})});
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // registers change only once the block has drained
   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      idle(SETTLE_CYCLES);
   endtask

   // loads every active channel with random content, biased to interesting spots
   task automatic load_all(int n);
      logic [15:0] s;
      logic [23:0] v;
      for (int c = 0; c < n; c++) begin
         case ($urandom_range(0, 5))
            0: s = 16'h0100;
            1: s = 16'h8000;
            2: s = 16'h7fff;
            default: s = 16'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: v = 24'($urandom_range(0, 3));
            1: v = 24'hffffff;
            2: v = 24'h010000;
            default: v = 24'($urandom);
         endcase
         load_param(c[7:0], s, 16'($urandom), 16'($urandom), v);
      end
   endtask

   initial begin
      int n_ch, n_units, total;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults (one channel, one unit, epsilon 1)
      load_param(8'd0, 16'h0100, 16'h0000, 16'h0000, 24'h010000);
      sample(16'h7fff);
      sample(16'h8000);
      sample(16'h0000);
      // zero scale with zero variance: factor 0, no clamp
      drain();
      write_reg(bn_inf_pkg::REG_EPSILON, 24'd0);
      load_param(8'd0, 16'h0000, 16'h7fff, 16'h8000, 24'd0);
      sample(16'h1234);
      // nonzero scale over zero variance clamps to the sign limit
      load_param(8'd0, 16'h8000, 16'h8000, 16'h7fff, 24'd0);
      sample(16'h8000);
      sample(16'h7fff);
      load_param(8'd0, 16'h0001, 16'h0000, 16'h0000, 24'd0);
      sample(16'hffff);
      // tiny scale over the largest variance: the factor rounds to zero
      load_param(8'd0, 16'h0001, 16'h0000, 16'h0000, 24'hffffff);
      sample(16'h0080);
      sample(16'hff80);
      drain();
      write_reg(bn_inf_pkg::REG_EPSILON, 24'hffffff);
      // zero counts act as one
      write_reg(bn_inf_pkg::REG_CHANNEL_COUNT, 24'd0);
      write_reg(bn_inf_pkg::REG_UNIT_COUNT, 24'd0);
      // an unused index does nothing
      write_reg(REG_UNUSED, 24'hffffff);
      load_param(8'd255, 16'h7fff, 16'h7fff, 16'h8000, 24'hffffff);
      sample(16'h4000);
      sample(16'hc000);
      drain();
      // three channels, two units; then shrink counts so positions sit beyond them
      write_reg(bn_inf_pkg::REG_CHANNEL_COUNT, 24'd3);
      write_reg(bn_inf_pkg::REG_UNIT_COUNT, 24'd2);
      load_all(3);
      repeat (3) sample(16'($urandom));
      drain();
      write_reg(bn_inf_pkg::REG_UNIT_COUNT, 24'd1);
      write_reg(bn_inf_pkg::REG_CHANNEL_COUNT, 24'd1);
      repeat (2) sample(16'($urandom));

      // random phases of images, full unless capped; mostly small shapes, a few extremes
      while (loads_sent + samples_sent < 1150) begin
         drain();
         case ($urandom_range(0, 9))
            0: begin n_ch = 256; n_units = 1; end
            1: begin n_ch = 1; n_units = 65536; end
            2: begin n_ch = 2; n_units = 70000; end
            3: begin n_ch = 300; n_units = 1; end
            default: begin n_ch = $urandom_range(1, 8); n_units = $urandom_range(1, 6); end
         endcase
         write_reg(bn_inf_pkg::REG_EPSILON,
                   24'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : $urandom));
         write_reg(bn_inf_pkg::REG_CHANNEL_COUNT, 24'(n_ch));
         write_reg(bn_inf_pkg::REG_UNIT_COUNT, 24'(n_units));
         active_channels = 9'(n_ch > 256 ? 256 : n_ch);
         load_all(active_channels);
         // cap long images; positions realign via a count rewrite afterwards
         total = active_channels * (n_units > 65536 ? 65536 : n_units);
         if (total > 120) total = 120 + $urandom_range(0, 20);
         repeat (total) sample(16'($urandom));
         // reset positions to zero: make every sample the last of its image
         drain();
         write_reg(bn_inf_pkg::REG_CHANNEL_COUNT, 24'd1);
         write_reg(bn_inf_pkg::REG_UNIT_COUNT, 24'd1);
         sample(16'($urandom));
      end

      drain();
      $display("covered %0d loads and %0d samples, %0d results checked",
               loads_sent, samples_sent, result_count);
      $display("shapes from 1x1 up to 256 channels and 65536 units, epsilon extremes");
      if (error_count == 0 && pending_count == 0) begin
         $display("batch_norm_inference: match");
      end else begin
         $display("batch_norm_inference: mismatch");
      end
      $finish;
   end
endmodule
